// ===== rtl/core/polar_rectangular_converter_assert.svh =====
// Assertion macros shared by the converter's checker.
`ifndef POLAR_RECTANGULAR_CONVERTER_ASSERT_SVH
`define POLAR_RECTANGULAR_CONVERTER_ASSERT_SVH

// Overlapping implication, sampled on clk, off while rst is high.
`define PRC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/prc_pkg.sv =====
// Shared constants, tables and types of the polar/rectangular converter.
`default_nettype none

package prc_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int ITERATIONS     = 16;

  localparam int GUARD  = 36 - COMPONENT_BITS;
  // component datapath: input, guard bits, growth headroom
  localparam int CW     = COMPONENT_BITS + GUARD + 4;
  localparam int ZW     = 32;
  localparam int ZSH    = ZW - ANGLE_BITS;
  localparam int GAIN_Q = 24;

  localparam logic [GAIN_Q-1:0] INV_GAIN = GAIN_Q'(10188014);

  // descale multiply is split into two partial products
  localparam int LO_BITS = CW / 2;
  localparam int HI_BITS = CW - LO_BITS;
  localparam int PW      = CW + GAIN_Q + 1;
  localparam int DSH     = GAIN_Q + GUARD;
  localparam int RW      = PW - DSH;

  localparam logic [PW-1:0] DS_RND  = PW'(1) << (DSH - 1);
  localparam logic [ZW-1:0] ANG_RND = ZW'(1) << (ZSH - 1);

  localparam logic [ZW-1:0] TURN_HALF    = ZW'(1) << (ZW - 1);
  localparam logic [ZW-1:0] TURN_QUARTER = ZW'(1) << (ZW - 2);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // accept edge to the edge that takes the result
  localparam int LATENCY = ITERATIONS + 4;

  typedef enum logic {
    CMD_TO_POLAR = 1'b0,
    CMD_TO_RECT  = 1'b1
  } prc_cmd_t;

  // atan(2^-i), 2^32 units per turn
  localparam logic [ZW-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // fields that ride along unchanged to the output stage
  typedef struct packed {
    prc_cmd_t                         cmd;
    logic signed [COMPONENT_BITS-1:0] xi;
    logic signed [COMPONENT_BITS-1:0] yi;
    logic        [COMPONENT_BITS-1:0] mag;
    logic        [ANGLE_BITS-1:0]     ang;
    logic                             zero;
  } prc_side_t;

  typedef struct packed {
    prc_side_t        side;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
  } prc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/prc_front.sv =====
// Front end: request handshake, sign/quadrant normalization, queue push.
`default_nettype none

module prc_front import prc_pkg::*; (
  input  logic                             rst,
  input  logic                             start,
  input  logic                             cmd,
  input  logic signed [COMPONENT_BITS-1:0] x_in,
  input  logic signed [COMPONENT_BITS-1:0] y_in,
  input  logic signed [COMPONENT_BITS-1:0] mag_in,
  input  logic        [ANGLE_BITS-1:0]     angle_in,
  input  logic                             q_full,
  output logic                             busy,
  output logic                             push,
  output prc_item_t                        item
);

  logic signed [CW-1:0]         xs;
  logic signed [CW-1:0]         ys;
  logic signed [CW-1:0]         ms;
  logic [COMPONENT_BITS-1:0]    mabs;
  logic [ANGLE_BITS-1:0]        a;
  logic [ZW-1:0]                za;
  logic [ZW-1:0]                zq;

  assign busy = rst || q_full;
  assign push = start && !busy;

  always_comb begin
    xs   = CW'(x_in) <<< GUARD;
    ys   = CW'(y_in) <<< GUARD;
    mabs = mag_in;
    a    = angle_in;
    // negative magnitude: flip it and add half a turn
    if (mag_in[COMPONENT_BITS-1]) begin
      mabs = (~mag_in) + COMPONENT_BITS'(1);
      a    = angle_in + {1'b1, {(ANGLE_BITS-1){1'b0}}};
    end
    ms = CW'({1'b0, mabs}) <<< GUARD;
    za = {a, {ZSH{1'b0}}};
    zq = za + TURN_QUARTER;

    item           = '0;
    item.side.cmd  = prc_cmd_t'(cmd);
    item.side.xi   = x_in;
    item.side.yi   = y_in;
    item.side.mag  = mabs;
    item.side.ang  = a;
    item.side.zero = (x_in == '0) && (y_in == '0);

    unique case (item.side.cmd)
      CMD_TO_POLAR: begin
        // left half plane: rotate by half a turn first
        if (x_in[COMPONENT_BITS-1]) begin
          item.x = -xs;
          item.y = -ys;
          item.z = TURN_HALF;
        end else begin
          item.x = xs;
          item.y = ys;
          item.z = '0;
        end
      end
      CMD_TO_RECT: begin
        item.y = '0;
        if (zq[ZW-1]) begin
          item.x = -ms;
          item.z = za + TURN_HALF;
        end else begin
          item.x = ms;
          item.z = za;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/prc_queue.sv =====
// Short request queue between the front end and the CORDIC back end.
`default_nettype none

module prc_queue import prc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  prc_item_t din,
  input  logic      pop,
  output prc_item_t dout,
  output logic      empty,
  output logic      full
);

  prc_item_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign dout  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

`default_nettype wire

// ===== rtl/core/prc_back.sv =====
// Back end: pipelined CORDIC, gain removal, rounding and saturation.
`default_nettype none

module prc_back import prc_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  prc_item_t                        q_item,
  output logic                             pop,
  output logic                             done,
  output logic signed [COMPONENT_BITS-1:0] x_out,
  output logic signed [COMPONENT_BITS-1:0] y_out,
  output logic        [COMPONENT_BITS-1:0] magnitude,
  output logic        [ANGLE_BITS-1:0]     angle_out,
  output logic                             saturated
);

  localparam logic signed [RW-1:0] SMAX = RW'({1'b0, {(COMPONENT_BITS-1){1'b1}}});
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);
  localparam logic signed [RW-1:0] UMAX = RW'({COMPONENT_BITS{1'b1}});

  logic      vld [1:ITERATIONS];
  prc_item_t st  [1:ITERATIONS];

  // the back end never stalls, so the queue drains every cycle
  assign pop = !q_empty;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 dir;
    logic                 cur_vld;
    prc_item_t            cur;
    prc_item_t            nxt;

    // first stage takes the queue head directly
    if (i == 0) begin : g_head
      assign cur_vld = pop;
      assign cur     = q_item;
    end else begin : g_tail
      assign cur_vld = vld[i];
      assign cur     = st[i];
    end

    always_comb begin
      nxt = cur;
      dx  = cur.y >>> i;
      dy  = cur.x >>> i;
      // vectoring drives y to zero, rotation drives z to zero
      dir = (cur.side.cmd == CMD_TO_POLAR) ? ~cur.y[CW-1] : cur.z[ZW-1];
      if (dir) begin
        nxt.x = cur.x + dx;
        nxt.y = cur.y - dy;
        nxt.z = cur.z + ATAN_TAB[i];
      end else begin
        nxt.x = cur.x - dx;
        nxt.y = cur.y + dy;
        nxt.z = cur.z - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= cur_vld;
      end
      st[i+1] <= nxt;
    end
  end

  // descale step 1: partial products with the inverse gain
  logic                             d1_vld;
  prc_side_t                        d1_side;
  logic [ZW-1:0]                    d1_z;
  logic        [LO_BITS+GAIN_Q-1:0] px_lo;
  logic        [LO_BITS+GAIN_Q-1:0] py_lo;
  logic signed [HI_BITS+GAIN_Q:0]   px_hi;
  logic signed [HI_BITS+GAIN_Q:0]   py_hi;
  logic signed [HI_BITS-1:0]        xh;
  logic signed [HI_BITS-1:0]        yh;

  assign xh = st[ITERATIONS].x[CW-1:LO_BITS];
  assign yh = st[ITERATIONS].y[CW-1:LO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else begin
      d1_vld <= vld[ITERATIONS];
    end
    d1_side <= st[ITERATIONS].side;
    d1_z    <= st[ITERATIONS].z;
    px_lo   <= st[ITERATIONS].x[LO_BITS-1:0] * INV_GAIN;
    py_lo   <= st[ITERATIONS].y[LO_BITS-1:0] * INV_GAIN;
    px_hi   <= xh * $signed({1'b0, INV_GAIN});
    py_hi   <= yh * $signed({1'b0, INV_GAIN});
  end

  // descale step 2: combine, round half up, drop guard and gain bits
  logic signed [PW-1:0] sx;
  logic signed [PW-1:0] sy;
  logic                 d2_vld;
  prc_side_t            d2_side;
  logic [ZW-1:0]        d2_z;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;

  always_comb begin
    sx = (PW'(px_hi) <<< LO_BITS) + PW'(px_lo) + DS_RND;
    sy = (PW'(py_hi) <<< LO_BITS) + PW'(py_lo) + DS_RND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld <= 1'b0;
    end else begin
      d2_vld <= d1_vld;
    end
    d2_side <= d1_side;
    d2_z    <= d1_z;
    rx      <= sx[PW-1:DSH];
    ry      <= sy[PW-1:DSH];
  end

  // output stage
  logic signed [COMPONENT_BITS-1:0] x_next;
  logic signed [COMPONENT_BITS-1:0] y_next;
  logic        [COMPONENT_BITS-1:0] mag_next;
  logic        [ANGLE_BITS-1:0]     ang_next;
  logic                             sat_next;
  logic        [ZW-1:0]             zr;

  always_comb begin
    zr       = d2_z + ANG_RND;
    x_next   = d2_side.xi;
    y_next   = d2_side.yi;
    mag_next = d2_side.mag;
    ang_next = d2_side.ang;
    sat_next = 1'b0;
    unique case (d2_side.cmd)
      CMD_TO_POLAR: begin
        if (d2_side.zero || rx[RW-1]) begin
          mag_next = '0;
        end else if (rx > UMAX) begin
          mag_next = '1;
        end else begin
          mag_next = rx[COMPONENT_BITS-1:0];
        end
        ang_next = d2_side.zero ? '0 : zr[ZW-1:ZSH];
      end
      CMD_TO_RECT: begin
        if (rx > SMAX) begin
          x_next   = SMAX[COMPONENT_BITS-1:0];
          sat_next = 1'b1;
        end else if (rx < SMIN) begin
          x_next   = SMIN[COMPONENT_BITS-1:0];
          sat_next = 1'b1;
        end else begin
          x_next = rx[COMPONENT_BITS-1:0];
        end
        if (ry > SMAX) begin
          y_next   = SMAX[COMPONENT_BITS-1:0];
          sat_next = 1'b1;
        end else if (ry < SMIN) begin
          y_next   = SMIN[COMPONENT_BITS-1:0];
          sat_next = 1'b1;
        end else begin
          y_next = ry[COMPONENT_BITS-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_vld;
    end
    x_out     <= x_next;
    y_out     <= y_next;
    magnitude <= mag_next;
    angle_out <= ang_next;
    saturated <= sat_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/polar_rectangular_converter.sv =====
// done follows each accepted request through the queue register, 16 CORDIC stages,
// two gain-removal stages and the output register.
// Throughput: one request per clock; the queue drains every cycle, so busy stays low while rst is low.
// Reset (rst, synchronous): busy is high while rst is high; all in-flight work is dropped
// and done stays low until new requests come through.
`default_nettype none

module polar_rectangular_converter import prc_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic signed [COMPONENT_BITS-1:0] x_in,
  input  logic signed [COMPONENT_BITS-1:0] y_in,
  input  logic signed [COMPONENT_BITS-1:0] mag_in,
  input  logic        [ANGLE_BITS-1:0]     angle_in,
  output logic                             done,
  output logic signed [COMPONENT_BITS-1:0] x_out,
  output logic signed [COMPONENT_BITS-1:0] y_out,
  output logic        [COMPONENT_BITS-1:0] magnitude,
  output logic        [ANGLE_BITS-1:0]     angle_out,
  output logic                             saturated
);

  prc_item_t f_item;
  prc_item_t q_item;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  prc_front u_front (
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .x_in     (x_in),
    .y_in     (y_in),
    .mag_in   (mag_in),
    .angle_in (angle_in),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .item     (f_item)
  );

  prc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .pop   (pop),
    .dout  (q_item),
    .empty (q_empty),
    .full  (q_full)
  );

  prc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .pop       (pop),
    .done      (done),
    .x_out     (x_out),
    .y_out     (y_out),
    .magnitude (magnitude),
    .angle_out (angle_out),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

// ===== rtl/core/prc_checker.sv =====
// Port-level checker for the converter and its bind to the top level.
`default_nettype none

`include "polar_rectangular_converter_assert.svh"

module prc_checker import prc_pkg::*; (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             cmd,
  input logic signed [COMPONENT_BITS-1:0] x_in,
  input logic signed [COMPONENT_BITS-1:0] y_in,
  input logic signed [COMPONENT_BITS-1:0] mag_in,
  input logic        [ANGLE_BITS-1:0]     angle_in,
  input logic                             done,
  input logic signed [COMPONENT_BITS-1:0] x_out,
  input logic signed [COMPONENT_BITS-1:0] y_out,
  input logic        [COMPONENT_BITS-1:0] magnitude,
  input logic        [ANGLE_BITS-1:0]     angle_out,
  input logic                             saturated
);

  localparam int SW = $clog2(LATENCY + 2);

  logic [SW-1:0] since_rst;
  logic          settled;

  // a full pipeline's worth of cycles with reset low
  assign settled = (since_rst > SW'(LATENCY));

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (!settled) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  `PRC_ASSERT_NEXT(a_no_spurious, !$past(start && !busy, LATENCY - 1), !done, "done without request")
  `PRC_ASSERT_IMPL(a_no_drop, settled && $past(start && !busy, LATENCY), done, "request lost")
  `PRC_ASSERT_IMPL(a_rect_echo, settled && $past(start && !busy && cmd == CMD_TO_POLAR, LATENCY), x_out == $past(x_in, LATENCY) && y_out == $past(y_in, LATENCY) && !saturated, "echo or flag wrong")
  `PRC_ASSERT_IMPL(a_polar_mag, settled && $past(start && !busy && cmd == CMD_TO_RECT && !mag_in[COMPONENT_BITS-1], LATENCY), magnitude == $past(mag_in, LATENCY) && angle_out == $past(angle_in, LATENCY), "polar pair not passed")

endmodule

bind polar_rectangular_converter prc_checker u_prc_checker (.*);

`default_nettype wire
